/* hw/rtl/fmm_pkg.sv */
// Package for the float matrix multiply engine: sizes, opcodes, FP helpers.
// Used by fmm_fpu.sv and float_matrix_multiply_engine.sv.
package fmm_pkg;
  localparam int MAX_DIM = 64;
  localparam int STORE_DEPTH = 4096;
  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CFG_W = 7;

  localparam logic [1:0] OP_WR_LEFT = 2'd0;
  localparam logic [1:0] OP_WR_RIGHT = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_INNER = 2'd2;
  localparam logic [1:0] REG_LAYOUT = 2'd3;

  localparam logic [31:0] QNAN = 32'h7FC00000;
  localparam logic [31:0] POS_ZERO = 32'h00000000;

  typedef struct packed {
    logic mul;
    logic add;
  } fpu_cmd_t;
endpackage

/* hw/rtl/fmm_fpu.sv */
// Shared single-precision multiply / add unit, round to nearest even.
// Multi-cycle: start pulse, done pulse. Depends on fmm_pkg.
module fmm_fpu (
  input  logic              clk,
  input  logic              rst_n,
  input  fmm_pkg::fpu_cmd_t cmd,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic              done,
  output logic [31:0]       res
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ALIGN, S_ADD, S_NORM, S_ROUND} st_t;
  st_t st_r;
  logic        sgn_r, sticky_r, op_sub_r;
  logic signed [10:0] exp_r;
  logic [49:0] man_r;
  logic [26:0] big_r, sml_r;
  logic [7:0]  sh_r;
  logic [31:0] res_r;
  logic        done_r;
  logic [23:0] ma, mb;
  logic [47:0] mprod;
  logic [7:0]  ea, eb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [27:0] asum;
  logic [49:0] man_sh;
  logic [5:0]  lz;
  logic [26:0] sml_sh;
  logic        sml_st;
  logic [23:0] rm;
  logic        g, st_b, rup;
  logic [24:0] rsum;
  logic signed [10:0] rexp;
  logic [7:0]  dsh;
  logic [49:0] den;
  logic        den_st;

  assign done = done_r;
  assign res = res_r;
  assign ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
  assign eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
  assign ma = {a[30:23] != 8'd0, a[22:0]};
  assign mb = {b[30:23] != 8'd0, b[22:0]};
  assign mprod = ma * mb;
  assign a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  assign b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  assign a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  assign b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
  assign a_zero = a[30:0] == 31'd0;
  assign b_zero = b[30:0] == 31'd0;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 50; i++) begin
      if (man_r[i]) lz = 6'(49 - i);
    end
    man_sh = man_r << lz;
    sml_sh = (sh_r >= 8'd27) ? 27'd0 : (sml_r >> sh_r);
    sml_st = (sh_r >= 8'd27) ? (sml_r != 27'd0)
           : ((sml_r & ((27'd1 << sh_r) - 27'd1)) != 27'd0);
    asum = op_sub_r ? ({1'b0, big_r} - {1'b0, sml_r}) : ({1'b0, big_r} + {1'b0, sml_r});
    // man_r[49] is the leading one after normalize; exponent of that bit = exp_r
    dsh = (exp_r < 11'sd1) ? ((exp_r < -11'sd30) ? 8'd31 : 8'(11'sd1 - exp_r)) : 8'd0;
    den = man_r >> dsh;
    den_st = (man_r & ((50'd1 << dsh) - 50'd1)) != 50'd0;
    rm = den[49:26];
    g = den[25];
    st_b = (den[24:0] != 25'd0) | den_st | sticky_r;
    rup = g & (st_b | rm[0]);
    rsum = {1'b0, rm} + {24'd0, rup};
    rexp = (dsh != 8'd0) ? (rsum[23] ? 11'sd1 : 11'sd0) : exp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (cmd.mul) begin
            sgn_r <= a[31] ^ b[31];
            sticky_r <= 1'b0;
            if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
              res_r <= fmm_pkg::QNAN; done_r <= 1'b1;
            end else if (a_inf || b_inf) begin
              res_r <= {a[31] ^ b[31], 8'hFF, 23'd0}; done_r <= 1'b1;
            end else if (a_zero || b_zero) begin
              res_r <= {a[31] ^ b[31], 31'd0}; done_r <= 1'b1;
            end else begin
              man_r <= {mprod, 2'b0};
              exp_r <= 11'(signed'({3'b0, ea})) + 11'(signed'({3'b0, eb})) - 11'sd126;
              st_r <= S_MUL;
            end
          end else if (cmd.add) begin
            sticky_r <= 1'b0;
            if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
              res_r <= fmm_pkg::QNAN; done_r <= 1'b1;
            end else if (a_inf) begin
              res_r <= a; done_r <= 1'b1;
            end else if (b_inf) begin
              res_r <= b; done_r <= 1'b1;
            end else if (a_zero && b_zero) begin
              res_r <= {a[31] & b[31], 31'd0}; done_r <= 1'b1;
            end else if (a_zero) begin
              res_r <= b; done_r <= 1'b1;
            end else if (b_zero) begin
              res_r <= a; done_r <= 1'b1;
            end else begin
              op_sub_r <= a[31] ^ b[31];
              if (a[30:0] >= b[30:0]) begin
                sgn_r <= a[31]; big_r <= {ma, 3'b0}; sml_r <= {mb, 3'b0};
                sh_r <= ea - eb; exp_r <= 11'(signed'({3'b0, ea})) + 11'sd1;
              end else begin
                sgn_r <= b[31]; big_r <= {mb, 3'b0}; sml_r <= {ma, 3'b0};
                sh_r <= eb - ea; exp_r <= 11'(signed'({3'b0, eb})) + 11'sd1;
              end
              st_r <= S_ALIGN;
            end
          end
        end
        S_MUL: st_r <= S_NORM;
        S_ALIGN: begin
          sml_r <= sml_sh;
          sticky_r <= sml_st;
          st_r <= S_ADD;
        end
        S_ADD: begin
          // sticky bit acts as a borrow below the lsb on subtraction
          if (asum == 28'd0 && !sticky_r) begin
            res_r <= 32'd0; done_r <= 1'b1; st_r <= S_IDLE;
          end else begin
            man_r <= {asum, 22'd0} - {49'd0, op_sub_r & sticky_r};
            st_r <= S_NORM;
          end
        end
        S_NORM: begin
          man_r <= man_sh;
          exp_r <= exp_r - 11'(signed'({5'b0, lz}));
          st_r <= S_ROUND;
        end
        default: begin
          if (rsum[24]) begin
            if (rexp + 11'sd1 >= 11'sd255) res_r <= {sgn_r, 8'hFF, 23'd0};
            else res_r <= {sgn_r, 8'(rexp + 11'sd1), rsum[23:1]};
          end else if (rexp >= 11'sd255) begin
            res_r <= {sgn_r, 8'hFF, 23'd0};
          end else begin
            res_r <= {sgn_r, (rsum[23] ? 8'(rexp) : 8'd0), rsum[22:0]};
          end
          done_r <= 1'b1;
          st_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule

/* hw/rtl/float_matrix_multiply_engine.sv */
// Float matrix multiply engine: input stream writes two stores or asks for
// the next product element. Depends on fmm_pkg and fmm_fpu.
//
// Input word tdata: op[1:0], element_index[13:2], element_bits[45:14].
// Ops 0/1 write the left/right store. Op 2 computes the next output element
// in row-major order through one shared FP unit: each inner step is a store
// read and multiply issue, a multiply and an add; zero, inf and NaN operands
// finish sooner. No new input word is accepted until an element's
// multiply-add chain is done; that chain sets the rate.
// Output word tdata: result_bits[31:0], out_row[37:32], out_col[43:38],
// tlast = is_last. The result sits in an output register; a new input is
// accepted while it waits, but a second compute holds until it is taken.
// Configuration writes take effect at once and do not move the walk.
// Reset clears walk counters and registers to 1,1,1,transposed; stores
// are undefined until written. No clearing pass.
module float_matrix_multiply_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op, element_index, element_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // result_bits, out_row, out_col
  output logic        out_tlast,  // is_last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);
  localparam int AW = fmm_pkg::ADDR_W;
  localparam int DW = fmm_pkg::DIM_W;
  typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL, S_WMUL, S_WADD, S_DONE} st_t;

  logic [31:0] left_mem [fmm_pkg::STORE_DEPTH];
  logic [31:0] right_mem [fmm_pkg::STORE_DEPTH];
  logic [6:0] rows_r, cols_r, inner_r;
  logic       trans_r;
  st_t        st_r;
  logic [DW-1:0] row_r, col_r;
  logic [6:0] k_r, rows_c, cols_c, inner_c;
  logic [AW-1:0] laddr_r, raddr_r, lstep, rstep;
  logic [31:0] ld_r, rd_r, acc_r;
  logic        ovalid_r, olast_r;
  logic [31:0] ores_r;
  logic [DW-1:0] orow_r, ocol_r;
  fmm_pkg::fpu_cmd_t cmd;
  logic [31:0] fa, fb, fres;
  logic        fdone, accept, last_c;
  logic [1:0]  op;
  logic [AW-1:0] idx;
  logic [31:0] bits;
  logic [DW-1:0] r0, c0;

  function automatic logic [6:0] clampd(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'(fmm_pkg::MAX_DIM)) return 7'(fmm_pkg::MAX_DIM);
    return v;
  endfunction

  assign op = in_tdata[1:0];
  assign idx = in_tdata[13:2];
  assign bits = in_tdata[45:14];
  assign rows_c = clampd(rows_r);
  assign cols_c = clampd(cols_r);
  assign inner_c = clampd(inner_r);
  assign in_tready = (st_r == S_IDLE) && !(ovalid_r && op == fmm_pkg::OP_COMPUTE);
  assign accept = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata = {4'd0, ocol_r, orow_r, ores_r};
  assign out_tlast = olast_r;
  assign lstep = AW'(1);
  assign rstep = trans_r ? AW'(1) : AW'(cols_c);
  // walk restarts if counters lie beyond the current dimensions
  assign r0 = ({1'b0, row_r} >= rows_c || {1'b0, col_r} >= cols_c) ? '0 : row_r;
  assign c0 = ({1'b0, row_r} >= rows_c || {1'b0, col_r} >= cols_c) ? '0 : col_r;
  assign last_c = ({1'b0, row_r} == rows_c - 7'd1) && ({1'b0, col_r} == cols_c - 7'd1);

  always_comb begin
    cmd = '0;
    fa = ld_r;
    fb = rd_r;
    if (st_r == S_MUL) cmd.mul = 1'b1;
    if (st_r == S_WMUL && fdone) begin
      cmd.add = 1'b1; fa = acc_r; fb = fres;
    end
  end

  fmm_fpu u_fpu (.clk(clk), .rst_n(rst_n), .cmd(cmd), .a(fa), .b(fb),
                 .done(fdone), .res(fres));

  always_ff @(posedge clk) begin
    if (accept && op == fmm_pkg::OP_WR_LEFT) left_mem[idx] <= bits;
    if (accept && op == fmm_pkg::OP_WR_RIGHT) right_mem[idx] <= bits;
    ld_r <= left_mem[laddr_r];
    rd_r <= right_mem[raddr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 7'd1; cols_r <= 7'd1; inner_r <= 7'd1; trans_r <= 1'b1;
      st_r <= S_IDLE; row_r <= '0; col_r <= '0; ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fmm_pkg::REG_ROWS:  rows_r <= cfg_wdata;
          fmm_pkg::REG_COLS:  cols_r <= cfg_wdata;
          fmm_pkg::REG_INNER: inner_r <= cfg_wdata;
          default:            trans_r <= cfg_wdata[0];
        endcase
      end
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (accept && op == fmm_pkg::OP_COMPUTE) begin
            row_r <= r0; col_r <= c0;
            laddr_r <= AW'(r0 * inner_c);
            raddr_r <= trans_r ? AW'(c0 * inner_c) : AW'(c0);
            k_r <= 7'd0; acc_r <= fmm_pkg::POS_ZERO;
            st_r <= S_RD;
          end
        end
        S_RD: st_r <= S_MUL;
        S_MUL: st_r <= S_WMUL;
        S_WMUL: if (fdone) begin
          st_r <= S_WADD;
        end
        S_WADD: if (fdone) begin
          acc_r <= fres;
          laddr_r <= laddr_r + lstep;
          raddr_r <= raddr_r + rstep;
          k_r <= k_r + 7'd1;
          st_r <= (k_r + 7'd1 >= inner_c) ? S_DONE : S_RD;
        end
        default: begin
          ovalid_r <= 1'b1;
          ores_r <= acc_r; orow_r <= row_r; ocol_r <= col_r; olast_r <= last_c;
          if (last_c) begin
            row_r <= '0; col_r <= '0;
          end else if ({1'b0, col_r} + 7'd1 >= cols_c) begin
            col_r <= '0; row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
          st_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule

/* test/float_matrix_multiply_engine_tb.sv */
// Self-checking testbench for float_matrix_multiply_engine: random store writes and
// compute requests, with a bit-exact single-precision predictor held in a scoreboard class.
// Depends on fmm_pkg and the engine RTL only.
module float_matrix_multiply_engine_tb;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 900;   // drain margin after the last element, covering one full dot product
  localparam int ITEM_TARGET = 1050;

  typedef struct packed {
    logic [31:0] bits;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        last;
  } product_elem_t;

  class matmul_scoreboard;
    logic [31:0] left_mem [fmm_pkg::STORE_DEPTH];
    logic [31:0] right_mem [fmm_pkg::STORE_DEPTH];
    bit left_set [fmm_pkg::STORE_DEPTH];
    bit right_set [fmm_pkg::STORE_DEPTH];
    logic [6:0] rows_reg = 7'd1, cols_reg = 7'd1, inner_reg = 7'd1;
    logic layout_reg = 1'b1;
    int walk_row, walk_col;
    product_elem_t pending[$];
    int errors;

    function int clamp(logic [6:0] v);
      if (v == 0) return 1;
      if (v > fmm_pkg::MAX_DIM) return fmm_pkg::MAX_DIM;
      return v;
    endfunction

    function real to_real(logic [31:0] b);
      real r;
      if (b[30:23] == 8'hff) return $bitstoreal({b[31], 11'h7ff, b[22:0], 29'h0});
      if (b[30:23] == 8'h00) begin
        r = b[22:0] * (2.0 ** -149);
        return b[31] ? -r : r;
      end
      return $bitstoreal({b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'h0});
    endfunction

    // round a double to single, nearest-even, with subnormals and overflow
    function logic [31:0] to_single(real r);
      logic [63:0] d, sig, kept, remv, half;
      logic s;
      int e, fe, sh;
      d = $realtobits(r);
      s = d[63];
      e = d[62:52];
      if (e == 2047) return (d[51:0] != 0) ? fmm_pkg::QNAN : {s, 8'hff, 23'h0};
      if (e == 0) return {s, 31'h0};
      fe = e - 1023 + 127;
      sig = {11'h0, 1'b1, d[51:0]};
      sh = (fe >= 1) ? 29 : 30 - fe;
      if (sh > 60) return {s, 31'h0};
      kept = sig >> sh;
      remv = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (remv > half || (remv == half && kept[0])) kept = kept + 1;
      if (fe >= 1) begin
        if (kept[24]) begin
          kept = kept >> 1;
          fe++;
        end
        if (fe >= 255) return {s, 8'hff, 23'h0};
        return {s, fe[7:0], kept[22:0]};
      end
      return {s, kept[30:0]};
    endfunction

    function void write_reg(logic [1:0] idx, logic [6:0] val);
      case (idx)
        fmm_pkg::REG_ROWS: rows_reg = val;
        fmm_pkg::REG_COLS: cols_reg = val;
        fmm_pkg::REG_INNER: inner_reg = val;
        fmm_pkg::REG_LAYOUT: layout_reg = val[0];
        default: ;
      endcase
    endfunction

    function int right_addr(int col, int k);
      if (layout_reg) return (col * clamp(inner_reg) + k) % fmm_pkg::STORE_DEPTH;
      return (k * clamp(cols_reg) + col) % fmm_pkg::STORE_DEPTH;
    endfunction

    function void wrap_walk();
      if (walk_row >= clamp(rows_reg) || walk_col >= clamp(cols_reg)) begin
        walk_row = 0;
        walk_col = 0;
      end
    endfunction

    // first store entry the next compute would read unwritten, or -1
    function int missing_entry(output bit on_right);
      int r, c, li, ri;
      r = walk_row;
      c = walk_col;
      if (r >= clamp(rows_reg) || c >= clamp(cols_reg)) begin
        r = 0;
        c = 0;
      end
      for (int k = 0; k < clamp(inner_reg); k++) begin
        li = (r * clamp(inner_reg) + k) % fmm_pkg::STORE_DEPTH;
        ri = right_addr(c, k);
        on_right = 0;
        if (!left_set[li]) return li;
        on_right = 1;
        if (!right_set[ri]) return ri;
      end
      return -1;
    endfunction

    function void note_word(logic [47:0] w);
      logic [1:0] op;
      logic [11:0] idx;
      logic [31:0] acc, prod;
      product_elem_t e;
      op = w[1:0];
      idx = w[13:2];
      if (op == fmm_pkg::OP_WR_LEFT) begin
        left_mem[idx] = w[45:14];
        left_set[idx] = 1;
      end else if (op == fmm_pkg::OP_WR_RIGHT) begin
        right_mem[idx] = w[45:14];
        right_set[idx] = 1;
      end else if (op == fmm_pkg::OP_COMPUTE) begin
        wrap_walk();
        acc = fmm_pkg::POS_ZERO;
        for (int k = 0; k < clamp(inner_reg); k++) begin
          prod = to_single(
            to_real(left_mem[(walk_row * clamp(inner_reg) + k) % fmm_pkg::STORE_DEPTH])
            * to_real(right_mem[right_addr(walk_col, k)]));
          acc = to_single(to_real(acc) + to_real(prod));
        end
        e.bits = acc;
        e.row = 6'(walk_row);
        e.col = 6'(walk_col);
        e.last = (walk_row == clamp(rows_reg) - 1) && (walk_col == clamp(cols_reg) - 1);
        pending.push_back(e);
        if (e.last) begin
          walk_row = 0;
          walk_col = 0;
        end else if (walk_col + 1 >= clamp(cols_reg)) begin
          walk_col = 0;
          walk_row++;
        end else begin
          walk_col++;
        end
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check(logic [47:0] d, logic last);
      product_elem_t e;
      if (pending.size() == 0) begin
        report("unexpected word", d[31:0], 0);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.bits) report("result_bits", d[31:0], e.bits);
      if (d[37:32] !== e.row) report("out_row", 32'(d[37:32]), 32'(e.row));
      if (d[43:38] !== e.col) report("out_col", 32'(d[43:38]), 32'(e.col));
      if (last !== e.last) report("is_last", 32'(last), 32'(e.last));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, out_tready = 0, cfg_we = 0;
  logic [47:0] in_tdata = '0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_wdata = '0;
  logic in_tready, out_tvalid, out_tlast;
  logic [47:0] out_tdata;

  matmul_scoreboard sb = new();
  int cycles, rx_hold, words_sent;
  bit rx_idle_on, tx_idle_on, hold_request;

  float_matrix_multiply_engine u_top (.*);

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("float_matrix_multiply_engine regression: fail");
      $finish;
    end
  end

  // receiver: one ready decision per falling edge
  always @(negedge clk) begin
    out_tready <= rst_n && rx_hold == 0;
    if (rx_hold > 0) rx_hold--;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check(out_tdata, out_tlast);
      rx_hold = rx_idle_on ? $urandom_range(0, 19) : 0;
      if (hold_request) begin
        rx_hold = 3000;
        hold_request = 0;
      end
    end
  end

  task send_word(logic [1:0] op, logic [11:0] idx, logic [31:0] bits);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 0;
    end
    @(negedge clk);
    in_tvalid <= 1;
    in_tdata <= {2'b00, bits, idx, op};
    do @(posedge clk); while (!in_tready);
    sb.note_word({2'b00, bits, idx, op});
    words_sent++;
    if (words_sent == 300) hold_request = 1;
  endtask

  task write_cfg(logic [1:0] idx, logic [6:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
  endtask

  task wait_idle();
    @(negedge clk);
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [31:0] pick_value(bit special);
    logic [31:0] odd [14] = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
      32'h7fc00000, 32'h7f800001, 32'h7f7fffff, 32'hff7fffff, 32'h00000001, 32'h807fffff,
      32'h00800000, 32'h3f800000, 32'hbf800000, 32'hffffffff};
    int p;
    p = $urandom_range(0, 99);
    if (special || p < 10) return odd[$urandom_range(0, 13)];
    if (p < 75) return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 140)),
                        23'($urandom)};
    return $urandom;
  endfunction

  task run_phase(logic [6:0] r, logic [6:0] c, logic [6:0] k, logic lay, int n, bit special);
    int miss, roll;
    bit on_right;
    write_cfg(fmm_pkg::REG_LAYOUT, {6'($urandom), lay});
    write_cfg(fmm_pkg::REG_INNER, k);
    write_cfg(fmm_pkg::REG_ROWS, r);
    write_cfg(fmm_pkg::REG_COLS, c);
    @(negedge clk);
    cfg_we <= 0;
    tx_idle_on = $urandom_range(0, 3) != 0;
    rx_idle_on = $urandom_range(0, 3) != 0;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      miss = sb.missing_entry(on_right);
      if (roll < 4) send_word(OP_IGNORED, 12'($urandom), $urandom);
      else if (roll < 10)
        send_word(2'($urandom_range(0, 1)), 12'($urandom), pick_value(special));
      else if (miss >= 0)
        send_word(on_right ? fmm_pkg::OP_WR_RIGHT : fmm_pkg::OP_WR_LEFT, 12'(miss),
                  pick_value(special));
      else if (roll < 65) send_word(fmm_pkg::OP_COMPUTE, 12'($urandom), $urandom);
      else begin
        // overwrite an entry the current geometry reads
        if (roll[0]) send_word(fmm_pkg::OP_WR_LEFT,
          12'($urandom_range(0, sb.clamp(sb.rows_reg) * sb.clamp(sb.inner_reg) - 1)),
          pick_value(special));
        else send_word(fmm_pkg::OP_WR_RIGHT,
          12'($urandom_range(0, sb.clamp(sb.cols_reg) * sb.clamp(sb.inner_reg) - 1)),
          pick_value(special));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    repeat (2) @(posedge clk);
    run_phase(7'd2, 7'd2, 7'd2, 1'b1, 24, 1);
    run_phase(7'd0, 7'd0, 7'd0, 1'b0, 30, 1);
    run_phase(7'd127, 7'd1, 7'd1, 1'b1, 150, 0);
    run_phase(7'd1, 7'd64, 7'd1, 1'b0, 150, 0);
    run_phase(7'd1, 7'd1, 7'd64, 1'b1, 140, 0);
    run_phase(7'd2, 7'd1, 7'd64, 1'b0, 140, 0);
    run_phase(7'd3, 7'd2, 7'd2, 1'b0, 40, 0);
    while (words_sent < ITEM_TARGET)
      run_phase(7'($urandom_range(1, 6)), 7'($urandom_range(1, 6)),
                7'($urandom_range(1, 8)), 1'($urandom_range(0, 1)), 50, 0);
    if (sb.errors == 0) $display("float_matrix_multiply_engine regression: pass");
    else $display("float_matrix_multiply_engine regression: fail");
    $finish;
  end
endmodule
